[hw/rtl/rsa_mexp_pkg.sv]
`timescale 1ns / 1ps

package rsa_mexp_pkg;

    localparam int KEY_BITS     = 32;
    localparam int PROD_BITS    = 2 * KEY_BITS;
    localparam int RED_CNT_BITS = $clog2(PROD_BITS);
    localparam int VALUE_WIDTH  = 32;
    localparam int CFG_WIDTH    = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [RED_CNT_BITS-1:0] RED_LAST = RED_CNT_BITS'(PROD_BITS - 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_MODULUS      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_EXPONENT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIVATE_EXPONENT = 2'd2;

    localparam logic [CFG_WIDTH-1:0] KEY_MODULUS_RST      = 32'd3233;
    localparam logic [CFG_WIDTH-1:0] PUBLIC_EXPONENT_RST  = 32'd17;
    localparam logic [CFG_WIDTH-1:0] PRIVATE_EXPONENT_RST = 32'd2753;

    typedef enum logic {
        MUL_ACC_SQ,
        MUL_SQ_SQ
    } mul_sel_t;

    typedef enum logic {
        WB_ACC,
        WB_SQ
    } wb_dest_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        mul_sel_t mul_sel;
        logic     red;
        logic     wb;
        wb_dest_t wb_dest;
        logic     exp_shift;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_lsb;
        logic exp_zero;
        logic mod_small;
    } dp_stat_t;

endpackage

[hw/rtl/rsa_modular_exponentiation_core.sv]
`timescale 1ns / 1ps
// Operation: the input is reduced modulo the key modulus into the square; then each exponent bit,
//   lowest first, up to the highest set bit, takes a multiply of accumulator by square if set and
//   a square of the square, each followed by a bit-serial reduction; the result is then loaded.
// Throughput: one item at a time; the bit-serial modular reduction (one bit a cycle) sets it.
// Reset: aresetn synchronous, active low; returns to idle and restores modulus 3233,
//   public exponent 17 and private exponent 2753.

module rsa_modular_exponentiation_core import rsa_mexp_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic [VALUE_WIDTH-1:0]  s_in_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [VALUE_WIDTH-1:0]  m_out_value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rsa_mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rsa_mexp_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_operation (s_operation),
        .s_in_value  (s_in_value),
        .cmd         (cmd),
        .stat        (stat),
        .m_out_value (m_out_value)
    );

endmodule

[hw/rtl/rsa_mexp_dp.sv]
`timescale 1ns / 1ps

module rsa_mexp_dp import rsa_mexp_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_data,
    input  logic                    s_operation,
    input  logic [VALUE_WIDTH-1:0]  s_in_value,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    output logic [VALUE_WIDTH-1:0]  m_out_value
);

    logic [CFG_WIDTH-1:0]   key_modulus_reg;
    logic [CFG_WIDTH-1:0]   public_exponent_reg;
    logic [CFG_WIDTH-1:0]   private_exponent_reg;

    logic [KEY_BITS-1:0]    mod_reg;
    logic [KEY_BITS-1:0]    exp_reg;
    logic [KEY_BITS-1:0]    acc_reg;
    logic [KEY_BITS-1:0]    sq_reg;
    logic [KEY_BITS-1:0]    rem_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [VALUE_WIDTH-1:0] out_reg;

    logic [KEY_BITS-1:0]    mul_a;
    logic [PROD_BITS-1:0]   prod_next;
    logic [KEY_BITS:0]      shifted;
    logic [KEY_BITS:0]      diff;
    logic [KEY_BITS-1:0]    rem_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_modulus_reg      <= KEY_MODULUS_RST;
            public_exponent_reg  <= PUBLIC_EXPONENT_RST;
            private_exponent_reg <= PRIVATE_EXPONENT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_KEY_MODULUS) begin
                key_modulus_reg <= cfg_data;
            end
            if (cfg_index == CFG_PUBLIC_EXPONENT) begin
                public_exponent_reg <= cfg_data;
            end
            if (cfg_index == CFG_PRIVATE_EXPONENT) begin
                private_exponent_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        mul_a     = (cmd.mul_sel == MUL_ACC_SQ) ? acc_reg : sq_reg;
        prod_next = {{KEY_BITS{1'b0}}, mul_a} * {{KEY_BITS{1'b0}}, sq_reg};
        shifted   = {rem_reg, prod_reg[PROD_BITS-1]};
        diff      = shifted - {1'b0, mod_reg};
        rem_next  = (shifted >= {1'b0, mod_reg}) ? diff[KEY_BITS-1:0]
                                                 : shifted[KEY_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prod_reg <= {{KEY_BITS{1'b0}}, s_in_value[KEY_BITS-1:0]};
            rem_reg  <= '0;
            acc_reg  <= KEY_BITS'(1);
            mod_reg  <= key_modulus_reg[KEY_BITS-1:0];
            exp_reg  <= s_operation ? private_exponent_reg[KEY_BITS-1:0]
                                    : public_exponent_reg[KEY_BITS-1:0];
        end else begin
            if (cmd.mul) begin
                prod_reg <= prod_next;
                rem_reg  <= '0;
            end else if (cmd.red) begin
                prod_reg <= {prod_reg[PROD_BITS-2:0], 1'b0};
                rem_reg  <= rem_next;
            end
            if (cmd.wb && cmd.wb_dest == WB_ACC) begin
                acc_reg <= rem_reg;
            end
            if (cmd.exp_shift) begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.wb && cmd.wb_dest == WB_SQ) begin
            sq_reg <= rem_reg;
        end
        if (cmd.out_load) begin
            out_reg <= stat.mod_small ? '0 : VALUE_WIDTH'(acc_reg);
        end
    end

    assign stat.exp_lsb   = exp_reg[0];
    assign stat.exp_zero  = (exp_reg == '0);
    assign stat.mod_small = (mod_reg[KEY_BITS-1:1] == '0);
    assign m_out_value    = out_reg;

endmodule

[hw/rtl/rsa_mexp_ctrl.sv]
`timescale 1ns / 1ps

module rsa_mexp_ctrl import rsa_mexp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_WB,
        ST_BIT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        DST_INIT,
        DST_ACC,
        DST_SQ
    } dest_t;

    state_t                  state_reg, state_next;
    dest_t                   dest_reg, dest_next;
    logic [RED_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        dest_next    = dest_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_SQ_SQ;
        cmd.wb_dest  = WB_SQ;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    dest_next  = DST_INIT;
                    cnt_next   = RED_LAST;
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                cmd.red  = 1'b1;
                cnt_next = cnt_reg - RED_CNT_BITS'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.wb      = 1'b1;
                cmd.wb_dest = (dest_reg == DST_ACC) ? WB_ACC : WB_SQ;
                unique case (dest_reg)
                    DST_ACC: begin
                        cmd.mul     = 1'b1;
                        cmd.mul_sel = MUL_SQ_SQ;
                        dest_next   = DST_SQ;
                        cnt_next    = RED_LAST;
                        state_next  = ST_RED;
                    end
                    DST_SQ: begin
                        cmd.exp_shift = 1'b1;
                        state_next    = ST_BIT;
                    end
                    default: begin
                        state_next = ST_BIT;
                    end
                endcase
            end
            ST_BIT: begin
                priority if (stat.exp_zero || stat.mod_small) begin
                    state_next = ST_FIN;
                end else if (stat.exp_lsb) begin
                    cmd.mul     = 1'b1;
                    cmd.mul_sel = MUL_ACC_SQ;
                    dest_next   = DST_ACC;
                    cnt_next    = RED_LAST;
                    state_next  = ST_RED;
                end else begin
                    cmd.mul     = 1'b1;
                    cmd.mul_sel = MUL_SQ_SQ;
                    dest_next   = DST_SQ;
                    cnt_next    = RED_LAST;
                    state_next  = ST_RED;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dest_reg    <= DST_INIT;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dest_reg    <= dest_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && state_reg == ST_RED))
        else $error("accepted transfer did not start reduction");

    a_red_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RED && cnt_reg == '0) |=> (state_reg == ST_WB))
        else $error("reduction did not end in write-back");

    a_out_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_valid && s_ready))
        else $error("result load did not raise m_valid");
`endif

endmodule

[test/tb_rsa_modular_exponentiation_core.sv]
`timescale 1ns / 1ps

module tb_rsa_modular_exponentiation_core;
    import rsa_mexp_pkg::*;

    localparam logic                    OP_ENCRYPT = 1'b0;
    localparam logic                    OP_DECRYPT = 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int                      CYCLE_LIMIT = 4000000;
    localparam int                      DRAIN_CYCLES = 4300;
    localparam int                      RANDOM_PHASES = 7;
    localparam int                      ITEMS_PER_PHASE = 17;

    typedef struct {
        logic                   op;
        logic [VALUE_WIDTH-1:0] value;
    } rsa_item_t;

    class modexp_scoreboard;
        logic [CFG_WIDTH-1:0]   modulus;
        logic [CFG_WIDTH-1:0]   pub_exp;
        logic [CFG_WIDTH-1:0]   priv_exp;
        logic [VALUE_WIDTH-1:0] expected_out[$];
        int                     errors;
        int                     checked;

        function new();
            modulus  = KEY_MODULUS_RST;
            pub_exp  = PUBLIC_EXPONENT_RST;
            priv_exp = PRIVATE_EXPONENT_RST;
            errors   = 0;
            checked  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_WIDTH-1:0] data);
            case (idx)
                CFG_KEY_MODULUS:      modulus  = data;
                CFG_PUBLIC_EXPONENT:  pub_exp  = data;
                CFG_PRIVATE_EXPONENT: priv_exp = data;
                default: ;
            endcase
        endfunction

        function logic [VALUE_WIDTH-1:0] power_mod(logic [KEY_BITS-1:0] base,
                                                   logic [KEY_BITS-1:0] power,
                                                   logic [KEY_BITS-1:0] m);
            logic [PROD_BITS-1:0] acc;
            logic [PROD_BITS-1:0] sq;
            logic [PROD_BITS-1:0] m_wide;
            if (m < 2) return '0;
            m_wide = PROD_BITS'(m);
            sq     = PROD_BITS'(base) % m_wide;
            acc    = PROD_BITS'(1);
            for (int k = 0; k < KEY_BITS; k++) begin
                if (power[k]) acc = (acc * sq) % m_wide;
                sq = (sq * sq) % m_wide;
            end
            return VALUE_WIDTH'(acc % m_wide);
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task note_input(logic op, logic [VALUE_WIDTH-1:0] value);
            expected_out.push_back(power_mod(value, (op == OP_DECRYPT) ? priv_exp : pub_exp,
                                             modulus));
        endtask

        task check_result(logic [VALUE_WIDTH-1:0] got);
            logic [VALUE_WIDTH-1:0] want;
            checked++;
            if (expected_out.size() == 0) begin
                report_mismatch($sformatf("unexpected result out_value=0x%08h", got));
            end else begin
                want = expected_out.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("result %0d out_value=0x%08h, expected 0x%08h",
                                              checked, got, want));
            end
        endtask
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]    cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_operation;
    logic [VALUE_WIDTH-1:0]  s_in_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [VALUE_WIDTH-1:0]  m_out_value;

    modexp_scoreboard sb;
    rsa_item_t        batch[$];
    bit               no_idle;
    int               items_sent;
    int               key_settings;
    int               cycle_count;

    rsa_modular_exponentiation_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_in_value  (s_in_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic program_key(logic [CFG_WIDTH-1:0] modulus, logic [CFG_WIDTH-1:0] pub,
                               logic [CFG_WIDTH-1:0] priv, bit spare_first,
                               logic [CFG_WIDTH-1:0] spare_data);
        if (spare_first) write_cfg(CFG_UNUSED, spare_data);
        write_cfg(CFG_KEY_MODULUS, modulus);
        write_cfg(CFG_PUBLIC_EXPONENT, pub);
        write_cfg(CFG_PRIVATE_EXPONENT, priv);
        if (!spare_first) write_cfg(CFG_UNUSED, spare_data);
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    task automatic send_item(rsa_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= it.op;
        s_in_value  <= it.value;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it.op, it.value);
        items_sent++;
    endtask

    task automatic add_item(logic op, logic [VALUE_WIDTH-1:0] value);
        rsa_item_t it;
        it.op    = op;
        it.value = value;
        batch.push_back(it);
    endtask

    task automatic run_batch();
        while (batch.size() != 0) send_item(batch.pop_front());
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_modulus();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 3);
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(2, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value(logic [CFG_WIDTH-1:0] modulus);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return (modulus < 2) ? $urandom : $urandom_range(0, modulus - 1);
            default: return $urandom;
        endcase
    endfunction

    // result side: ready either waits ahead of valid or lags it by a random stall
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!no_idle && $urandom_range(0, 1)) begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                stall = $urandom_range(0, 4);
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
                do @(posedge aclk); while (!m_valid);
            end else begin
                m_ready <= 1'b1;
                do @(posedge aclk); while (!m_valid);
            end
            sb.check_result(m_out_value);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [CFG_WIDTH-1:0] modulus;
        sb           = new();
        no_idle      = 1'b0;
        items_sent   = 0;
        key_settings = 1;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_KEY_MODULUS;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_operation <= OP_ENCRYPT;
        s_in_value  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset key: n = 61 * 53, e = 17, d = 2753
        add_item(OP_ENCRYPT, 32'd65);
        add_item(OP_DECRYPT, 32'd2790);
        add_item(OP_ENCRYPT, 32'd0);
        add_item(OP_DECRYPT, 32'd0);
        add_item(OP_ENCRYPT, 32'hFFFF_FFFF);
        add_item(OP_DECRYPT, 32'hFFFF_FFFF);
        add_item(OP_ENCRYPT, 32'd3233);
        add_item(OP_ENCRYPT, 32'd3232);
        add_item(OP_DECRYPT, 32'd1);
        run_batch();

        // largest modulus, zero and all-ones exponents
        program_key(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        add_item(OP_ENCRYPT, 32'd123);
        add_item(OP_DECRYPT, 32'hFFFF_FFFE);
        add_item(OP_DECRYPT, 32'h8000_0000);
        add_item(OP_ENCRYPT, 32'hFFFF_FFFF);
        run_batch();

        // modulus one: every result zero, zero exponent too
        program_key(32'd1, 32'd0, 32'd5, 1'b1, 32'h5A5A_5A5A);
        add_item(OP_ENCRYPT, 32'd7);
        add_item(OP_DECRYPT, 32'hFFFF_FFFF);
        run_batch();

        // modulus zero: no multiply steps, result zero
        program_key(32'd0, 32'd3, 32'd0, 1'b0, 32'h0000_0000);
        add_item(OP_ENCRYPT, 32'd9);
        add_item(OP_DECRYPT, 32'd0);
        run_batch();

        // smallest valid modulus; spare index writes must not disturb the key
        program_key(32'd2, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF);
        add_item(OP_ENCRYPT, 32'd3);
        add_item(OP_DECRYPT, 32'hFFFF_FFFE);
        add_item(OP_ENCRYPT, 32'd2);
        run_batch();

        program_key(32'h8000_0000, 32'd65537, 32'h7FFF_FFFF, 1'b1, 32'd0);
        add_item(OP_ENCRYPT, $urandom);
        add_item(OP_DECRYPT, $urandom);
        run_batch();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_idle = (p % 3 == 1);
            modulus = pick_modulus();
            program_key(modulus, pick_exponent(), pick_exponent(), 1'($urandom_range(0, 1)),
                        $urandom);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                add_item($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, pick_value(modulus));
            run_batch();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items under %0d key settings, %0d results checked, %0d mismatches",
                 items_sent, key_settings, sb.checked, sb.errors);
        $display("Keys spanned modulus 0, 1, 2 and all-ones, zero and all-ones exponents");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rsa_mexp_pkg.sv
hw/rtl/rsa_mexp_dp.sv
hw/rtl/rsa_mexp_ctrl.sv
hw/rtl/rsa_modular_exponentiation_core.sv
test/tb_rsa_modular_exponentiation_core.sv
